>>> sv/vm86_sensitive_insn_monitor_top_defines.svh
// ----------------------------------------------------------------------------
// vm86_sensitive_insn_monitor_top_defines
// Assertion macros shared by the monitor RTL.
// ----------------------------------------------------------------------------
`ifndef VM86_SENSITIVE_INSN_MONITOR_TOP_DEFINES_SVH
`define VM86_SENSITIVE_INSN_MONITOR_TOP_DEFINES_SVH

// Checks that a condition implies a consequence on the same edge.
`define VM_ASSERT_IMPL(lbl, clk_s, rst_n, a, b, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (a) |-> (b)) \
		else $error(msg);

// Checks that a condition implies a consequence on the next edge.
`define VM_ASSERT_NEXT(lbl, clk_s, rst_n, a, b, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (a) |=> (b)) \
		else $error(msg);

`endif

>>> sv/vm86_pkg.sv
// ----------------------------------------------------------------------------
// vm86_pkg
// Types, codes and constants for the virtual-8086 instruction monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vm86_pkg;

	localparam int unsigned MaxPrefixDefault = 14;
	localparam int unsigned MaxRes = 5;

	localparam logic [3:0] ACT_RDBYTE  = 4'd0;
	localparam logic [3:0] ACT_RDWORD  = 4'd1;
	localparam logic [3:0] ACT_RDDWORD = 4'd2;
	localparam logic [3:0] ACT_WRWORD  = 4'd3;
	localparam logic [3:0] ACT_WRDWORD = 4'd4;
	localparam logic [3:0] ACT_PORTEN  = 4'd5;
	localparam logic [3:0] ACT_DONE    = 4'd6;
	localparam logic [3:0] ACT_SFAULT  = 4'd7;
	localparam logic [3:0] ACT_UNHAND  = 4'd8;

	localparam logic OPC_START = 1'b0;
	localparam logic OPC_DATA  = 1'b1;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_FETCH  = 4'd1,
		PH_INTNUM = 4'd2,
		PH_INTIP  = 4'd3,
		PH_INTCS  = 4'd4,
		PH_POPF   = 4'd5,
		PH_IRIP   = 4'd6,
		PH_IRCS   = 4'd7,
		PH_IRFL   = 4'd8,
		PH_PORTB  = 4'd9,
		PH_PORTW  = 4'd10
	} phase_t;

	localparam logic [31:0] IF_BIT = 32'h0000_0200;
	localparam int unsigned OP32_IDX = 6;

	typedef struct packed {
		logic        opcode;
		logic [15:0] cs_in;
		logic [31:0] ip_in;
		logic [31:0] sp_in;
		logic [15:0] ss_in;
		logic [31:0] flags_in;
		logic [15:0] dx_in;
		logic [31:0] read_data;
	} in_word_t;

	typedef struct packed {
		logic [3:0]  action;
		logic [20:0] mem_address;
		logic [31:0] write_value;
		logic [16:0] port_number;
		logic [15:0] cs_out;
		logic [31:0] ip_out;
		logic [31:0] sp_out;
		logic [31:0] flags_out;
		logic        last;
	} out_word_t;

	typedef struct packed {
		logic [15:0] code_seg;
		logic [31:0] instr_ptr;
		logic [31:0] start_ptr;
		logic [31:0] stack_ptr;
		logic [15:0] stack_seg;
		logic [31:0] flag_bits;
		logic [15:0] port_base;
		logic [10:0] prefix_marks;
		logic [3:0]  prefix_count;
		phase_t      phase;
		logic [7:0]  vec_num;
	} arch_state_t;

	function automatic logic [20:0] lin(input logic [15:0] seg, input logic [15:0] off);
		lin = {1'b0, seg, 4'h0} + {5'h0, off};
	endfunction

	function automatic logic [4:0] prefix_bit(input logic [7:0] b);
		unique case (b)
			8'h26: prefix_bit = 5'd0;
			8'h2E: prefix_bit = 5'd1;
			8'h36: prefix_bit = 5'd2;
			8'h3E: prefix_bit = 5'd3;
			8'h64: prefix_bit = 5'd4;
			8'h65: prefix_bit = 5'd5;
			8'h66: prefix_bit = 5'd6;
			8'h67: prefix_bit = 5'd7;
			8'hF0: prefix_bit = 5'd8;
			8'hF2: prefix_bit = 5'd9;
			8'hF3: prefix_bit = 5'd10;
			default: prefix_bit = 5'h1F;
		endcase
	endfunction

endpackage

>>> sv/vm86_sensitive_insn_monitor_top.sv
// ----------------------------------------------------------------------------
// vm86_sensitive_insn_monitor_top
// Monitor that emulates trapped sensitive instructions of virtual-8086 code.
// ----------------------------------------------------------------------------
// Input channel (in, in_valid, in_stall): a start word loads the trapped
// registers; data words answer the read request last issued.
// Output channel (out, out_valid, out_stall): up to five result words per
// input word, the final one flagged by last.
// One input word is taken per cycle while in_stall is low; a single pass of
// combinational logic updates the emulation state and builds all results
// into a registered result buffer. Results appear in the cycle after
// acceptance and leave one per cycle unless the receiver stalls; a
// one-result item then sustains one word per cycle.
// The input is stalled only while the result buffer still holds words that
// will not drain this cycle.
// Reset clears all state; the monitor is idle and the buffer empty.
// Receiver stall holds the current result word stable.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "vm86_sensitive_insn_monitor_top_defines.svh"

module vm86_sensitive_insn_monitor_top #(
	parameter int unsigned MAX_PREFIX = vm86_pkg::MaxPrefixDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  vm86_pkg::in_word_t  in,
	input  logic                in_valid,
	output logic                in_stall,
	output vm86_pkg::out_word_t out,
	output logic                out_valid,
	input  logic                out_stall
);

	vm86_pkg::arch_state_t st_q, nxt;
	vm86_pkg::out_word_t   res [vm86_pkg::MaxRes];
	vm86_pkg::out_word_t   buf_q [vm86_pkg::MaxRes];
	logic [2:0]            res_cnt;
	logic [2:0]            cnt_q, rd_q;
	logic                  acc, pop, drained;

	vm86_step #(.MAX_PREFIX(MAX_PREFIX)) u_step (
		.word(in), .cur(st_q), .nxt(nxt), .res(res), .res_cnt(res_cnt)
	);

	assign out_valid = cnt_q != 3'd0;
	assign out = buf_q[rd_q];
	assign pop = out_valid && !out_stall;
	assign drained = (cnt_q == 3'd0) || (pop && cnt_q == 3'd1);
	assign in_stall = !drained;
	assign acc = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
			cnt_q <= '0;
			rd_q <= '0;
		end else begin
			if (acc) begin
				st_q <= nxt;
				cnt_q <= res_cnt;
				rd_q <= '0;
			end else if (pop) begin
				cnt_q <= cnt_q - 3'd1;
				rd_q <= rd_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			buf_q <= res;
		end
	end

	`VM_ASSERT_IMPL(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= 3'd5, "result count too big")
	`VM_ASSERT_IMPL(a_last_end, clk, arst_n, out_valid, out.last == (cnt_q == 3'd1),
		"last misplaced")
	`VM_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid,
		"result dropped under stall")

endmodule

>>> sv/vm86_step.sv
// ----------------------------------------------------------------------------
// vm86_step
// Next-state and result logic for one accepted word (up to five results).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vm86_step #(
	parameter int unsigned MAX_PREFIX = vm86_pkg::MaxPrefixDefault
) (
	input  vm86_pkg::in_word_t    word,
	input  vm86_pkg::arch_state_t cur,
	output vm86_pkg::arch_state_t nxt,
	output vm86_pkg::out_word_t   res [vm86_pkg::MaxRes],
	output logic [2:0]            res_cnt
);

	always_comb begin
		vm86_pkg::arch_state_t s;
		logic [2:0] n;
		logic       o32;
		logic [4:0] pb;
		logic [7:0] b;
		logic [31:0] d;
		logic [15:0] pbase;
		logic [3:0] fin;
		logic       do_fin;
		logic [15:0] off;

		s = cur;
		n = 3'd0;
		fin = vm86_pkg::ACT_DONE;
		do_fin = 1'b0;
		pbase = '0;
		d = word.read_data;
		b = d[7:0];
		pb = vm86_pkg::prefix_bit(b);
		off = '0;
		for (int i = 0; i < vm86_pkg::MaxRes; i++) begin
			res[i] = '0;
		end
		o32 = cur.prefix_marks[vm86_pkg::OP32_IDX];

		if (word.opcode == vm86_pkg::OPC_START) begin
			s.code_seg = word.cs_in;
			s.instr_ptr = word.ip_in;
			s.start_ptr = word.ip_in;
			s.stack_ptr = word.sp_in;
			s.stack_seg = word.ss_in;
			s.flag_bits = word.flags_in;
			s.port_base = word.dx_in;
			s.prefix_marks = '0;
			s.prefix_count = '0;
			res[0].action = vm86_pkg::ACT_RDBYTE;
			res[0].mem_address = vm86_pkg::lin(s.code_seg, s.instr_ptr[15:0]);
			s.instr_ptr = {16'h0, s.instr_ptr[15:0] + 16'd1};
			s.phase = vm86_pkg::PH_FETCH;
			n = 3'd1;
		end else begin
			unique case (cur.phase)
				vm86_pkg::PH_FETCH: begin
					if (pb != 5'h1F) begin
						if (32'(cur.prefix_count) >= MAX_PREFIX) begin
							fin = vm86_pkg::ACT_UNHAND;
							do_fin = 1'b1;
						end else begin
							s.prefix_marks[pb[3:0]] = 1'b1;
							s.prefix_count = cur.prefix_count + 4'd1;
							res[0].action = vm86_pkg::ACT_RDBYTE;
							res[0].mem_address = vm86_pkg::lin(s.code_seg,
								s.instr_ptr[15:0]);
							s.instr_ptr = {16'h0, s.instr_ptr[15:0] + 16'd1};
							n = 3'd1;
						end
					end else begin
						unique case (b)
							8'h9C: begin
								off = cur.stack_ptr[15:0] - (o32 ? 16'd4 : 16'd2);
								s.stack_ptr = {16'h0, off};
								res[0].action = o32 ? vm86_pkg::ACT_WRDWORD
									: vm86_pkg::ACT_WRWORD;
								res[0].mem_address = vm86_pkg::lin(s.stack_seg, off);
								res[0].write_value = o32 ? cur.flag_bits
									: {16'h0, cur.flag_bits[15:0]};
								n = 3'd1;
								do_fin = 1'b1;
							end
							8'h9D, 8'hCF: begin
								if (cur.stack_ptr > (b == 8'h9D ?
									(o32 ? 32'hFFFC : 32'hFFFE) :
									(o32 ? 32'hFFF4 : 32'hFFFA))) begin
									fin = vm86_pkg::ACT_SFAULT;
									do_fin = 1'b1;
								end else begin
									res[0].action = o32 ? vm86_pkg::ACT_RDDWORD
										: vm86_pkg::ACT_RDWORD;
									res[0].mem_address = vm86_pkg::lin(s.stack_seg,
										cur.stack_ptr[15:0]);
									s.stack_ptr = {16'h0, cur.stack_ptr[15:0]
										+ (o32 ? 16'd4 : 16'd2)};
									s.phase = (b == 8'h9D) ? vm86_pkg::PH_POPF
										: vm86_pkg::PH_IRIP;
									n = 3'd1;
								end
							end
							8'hCD, 8'hE4, 8'hE6, 8'hE5, 8'hE7: begin
								res[0].action = vm86_pkg::ACT_RDBYTE;
								res[0].mem_address = vm86_pkg::lin(s.code_seg,
									s.instr_ptr[15:0]);
								s.instr_ptr = {16'h0, s.instr_ptr[15:0] + 16'd1};
								s.phase = (b == 8'hCD) ? vm86_pkg::PH_INTNUM :
									(b[0] ? vm86_pkg::PH_PORTW : vm86_pkg::PH_PORTB);
								n = 3'd1;
							end
							8'h6C, 8'h6E, 8'hEC, 8'hEE: begin
								res[0].action = vm86_pkg::ACT_PORTEN;
								res[0].port_number = {1'b0, cur.port_base};
								s.instr_ptr = cur.start_ptr;
								n = 3'd1;
								do_fin = 1'b1;
							end
							8'h6D, 8'h6F, 8'hED, 8'hEF: begin
								pbase = cur.port_base;
								for (int k = 0; k < 4; k++) begin
									res[k].action = vm86_pkg::ACT_PORTEN;
									res[k].port_number = {1'b0, pbase} + 17'(k);
								end
								n = o32 ? 3'd4 : 3'd2;
								s.instr_ptr = cur.start_ptr;
								do_fin = 1'b1;
							end
							8'hFA: begin
								s.flag_bits = cur.flag_bits & ~vm86_pkg::IF_BIT;
								do_fin = 1'b1;
							end
							8'hFB: begin
								s.flag_bits = cur.flag_bits | vm86_pkg::IF_BIT;
								do_fin = 1'b1;
							end
							default: begin
								fin = vm86_pkg::ACT_UNHAND;
								do_fin = 1'b1;
							end
						endcase
					end
				end
				vm86_pkg::PH_INTNUM: begin
					s.vec_num = b;
					off = cur.stack_ptr[15:0] - 16'd2;
					res[0].action = vm86_pkg::ACT_WRWORD;
					res[0].mem_address = vm86_pkg::lin(cur.stack_seg, off);
					res[0].write_value = {16'h0, cur.flag_bits[15:0]};
					off = off - 16'd2;
					res[1].action = vm86_pkg::ACT_WRWORD;
					res[1].mem_address = vm86_pkg::lin(cur.stack_seg, off);
					res[1].write_value = {16'h0, cur.code_seg};
					off = off - 16'd2;
					res[2].action = vm86_pkg::ACT_WRWORD;
					res[2].mem_address = vm86_pkg::lin(cur.stack_seg, off);
					res[2].write_value = {16'h0, cur.instr_ptr[15:0]};
					s.stack_ptr = {16'h0, off};
					s.flag_bits = cur.flag_bits & ~vm86_pkg::IF_BIT;
					res[3].action = vm86_pkg::ACT_RDWORD;
					res[3].mem_address = {11'h0, b, 2'b00};
					s.phase = vm86_pkg::PH_INTIP;
					n = 3'd4;
				end
				vm86_pkg::PH_INTIP: begin
					s.instr_ptr = {cur.instr_ptr[31:16], d[15:0]};
					res[0].action = vm86_pkg::ACT_RDWORD;
					res[0].mem_address = {11'h0, cur.vec_num, 2'b10};
					s.phase = vm86_pkg::PH_INTCS;
					n = 3'd1;
				end
				vm86_pkg::PH_INTCS: begin
					s.code_seg = d[15:0];
					do_fin = 1'b1;
				end
				vm86_pkg::PH_POPF, vm86_pkg::PH_IRFL: begin
					s.flag_bits = o32 ? d : {cur.flag_bits[31:16], d[15:0]};
					do_fin = 1'b1;
				end
				vm86_pkg::PH_IRIP, vm86_pkg::PH_IRCS: begin
					if (cur.phase == vm86_pkg::PH_IRIP) begin
						s.instr_ptr = o32 ? d : {16'h0, d[15:0]};
						s.phase = vm86_pkg::PH_IRCS;
					end else begin
						s.code_seg = d[15:0];
						s.phase = vm86_pkg::PH_IRFL;
					end
					res[0].action = o32 ? vm86_pkg::ACT_RDDWORD : vm86_pkg::ACT_RDWORD;
					res[0].mem_address = vm86_pkg::lin(cur.stack_seg, cur.stack_ptr[15:0]);
					s.stack_ptr = {16'h0, cur.stack_ptr[15:0] + (o32 ? 16'd4 : 16'd2)};
					n = 3'd1;
				end
				vm86_pkg::PH_PORTB: begin
					res[0].action = vm86_pkg::ACT_PORTEN;
					res[0].port_number = {9'h0, b};
					s.instr_ptr = cur.start_ptr;
					n = 3'd1;
					do_fin = 1'b1;
				end
				vm86_pkg::PH_PORTW: begin
					for (int k = 0; k < 4; k++) begin
						res[k].action = vm86_pkg::ACT_PORTEN;
						res[k].port_number = {9'h0, b} + 17'(k);
					end
					n = o32 ? 3'd4 : 3'd2;
					s.instr_ptr = cur.start_ptr;
					do_fin = 1'b1;
				end
				default: s.phase = vm86_pkg::PH_IDLE;
			endcase
		end

		if (do_fin) begin
			res[n] = '0;
			res[n].action = fin;
			res[n].cs_out = s.code_seg;
			res[n].ip_out = s.instr_ptr;
			res[n].sp_out = s.stack_ptr;
			res[n].flags_out = s.flag_bits;
			s.phase = vm86_pkg::PH_IDLE;
			n = n + 3'd1;
		end
		if (n != 3'd0) begin
			res[n - 3'd1].last = 1'b1;
		end
		nxt = s;
		res_cnt = n;
	end

endmodule
